### rtl/core/mpct_pkg.sv
// shared types and constants for the mouse packet cursor tracker
`default_nettype none

package mpct_pkg;

    // result kinds carried in the low bits of tuser
    localparam logic [1:0] KIND_MOVE = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    // button ids carried in the high bits of tuser
    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    // configuration register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // reset screen size
    localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd640;
    localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd480;

    // beat widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 4;
    localparam int ADDR_W     = 3;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // one classified packet: position, motion and button changes
    typedef struct packed {
        logic [15:0]       pos_x;
        logic [15:0]       pos_y;
        logic signed [7:0] rel_x;
        logic signed [8:0] rel_y;
        logic              left_chg;
        logic              left_down;
        logic              right_chg;
        logic              right_down;
    } job_t;

    // queue status seen by back and top level
    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

### rtl/core/mpct_front.sv
// front part: accepts packets, tracks cursor and buttons, builds jobs
`default_nettype none

module mpct_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [7:0]                  buttons_byte,
    input  wire logic signed [7:0]           delta_x,
    input  wire logic signed [7:0]           delta_y,
    input  wire logic [15:0]                 screen_width,
    input  wire logic [15:0]                 screen_height,
    output mpct_pkg::job_t                   job
);
    import mpct_pkg::*;

    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic        left_held_reg, right_held_reg;
    logic        centered_reg;

    logic [15:0]        base_x, base_y;
    logic signed [17:0] sum_x, sum_y;
    logic               left_press, right_press;

    // start from the screen center on the first packet
    always_comb
    begin
        base_x = centered_reg ? cursor_x_reg : {1'b0, screen_width[15:1]};
        base_y = centered_reg ? cursor_y_reg : {1'b0, screen_height[15:1]};
    end

    // move and clamp to 0 through the limit, both included
    always_comb
    begin
        sum_x = $signed({2'b00, base_x}) + 18'(delta_x);
        sum_y = $signed({2'b00, base_y}) - 18'(delta_y);
        if (sum_x[17])
            cursor_x_next = 16'd0;
        else if (sum_x[16:0] > {1'b0, screen_width})
            cursor_x_next = screen_width;
        else
            cursor_x_next = sum_x[15:0];
        if (sum_y[17])
            cursor_y_next = 16'd0;
        else if (sum_y[16:0] > {1'b0, screen_height})
            cursor_y_next = screen_height;
        else
            cursor_y_next = sum_y[15:0];
    end

    // classify button changes
    always_comb
    begin
        left_press      = buttons_byte[0];
        right_press     = buttons_byte[1];
        job.pos_x       = cursor_x_next;
        job.pos_y       = cursor_y_next;
        job.rel_x       = delta_x;
        job.rel_y       = -9'(delta_y);
        job.left_chg    = left_press != left_held_reg;
        job.left_down   = left_press;
        job.right_chg   = right_press != right_held_reg;
        job.right_down  = right_press;
    end

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            left_held_reg  <= 1'b0;
            right_held_reg <= 1'b0;
            centered_reg   <= 1'b0;
        end
        else if (accept)
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            left_held_reg  <= left_press;
            right_held_reg <= right_press;
            centered_reg   <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mpct_queue.sv
// short job queue between front and back
`default_nettype none

module mpct_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire mpct_pkg::job_t         push_job,
    input  wire logic                   pop,
    output mpct_pkg::job_t              head_job,
    output mpct_pkg::queue_status_t     status
);
    import mpct_pkg::*;

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_comb
    begin
        head_job      = entry_reg[rd_ptr_reg];
        status.count  = count_reg;
        status.full   = count_reg == CNT_W'(QUEUE_DEPTH);
        status.empty  = count_reg == '0;
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mpct_back.sv
// back part: walks each job and sends its results one beat at a time
`default_nettype none

module mpct_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mpct_pkg::job_t       head_job,
    input  wire logic                 queue_empty,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [mpct_pkg::OUT_DATA_W-1:0] m_tdata,  // pos_x, pos_y, rel_x, rel_y, zero pad
    output logic [mpct_pkg::OUT_USER_W-1:0] m_tuser,  // event_kind, button_id
    output logic                      m_tlast
);
    import mpct_pkg::*;

    job_t job_reg;
    logic job_valid_reg;
    logic move_pend_reg, left_pend_reg, right_pend_reg;

    logic              out_valid_reg;
    logic [1:0]        kind_reg, btn_reg;
    logic [15:0]       pos_x_reg, pos_y_reg;
    logic signed [7:0] rel_x_reg;
    logic signed [8:0] rel_y_reg;
    logic              last_reg;

    logic       slot_free, emit, done, load;
    logic [1:0] sel_kind, sel_btn;
    logic       sel_last, sel_move;

    // pick the next result of the current job
    always_comb
    begin
        slot_free = !out_valid_reg || m_tready;
        emit      = job_valid_reg && slot_free;
        sel_move  = move_pend_reg;
        if (move_pend_reg)
        begin
            sel_kind = KIND_MOVE;
            sel_btn  = BTN_NONE;
            sel_last = !left_pend_reg && !right_pend_reg;
        end
        else if (left_pend_reg)
        begin
            sel_kind = job_reg.left_down ? KIND_DOWN : KIND_UP;
            sel_btn  = BTN_LEFT;
            sel_last = !right_pend_reg;
        end
        else
        begin
            sel_kind = job_reg.right_down ? KIND_DOWN : KIND_UP;
            sel_btn  = BTN_RIGHT;
            sel_last = 1'b1;
        end
        done = emit && sel_last;
        load = (!job_valid_reg || done) && !queue_empty;
        pop  = load;
    end

    // job register and pending results
    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= head_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg  <= 1'b0;
            move_pend_reg  <= 1'b0;
            left_pend_reg  <= 1'b0;
            right_pend_reg <= 1'b0;
        end
        else if (load)
        begin
            job_valid_reg  <= 1'b1;
            move_pend_reg  <= 1'b1;
            left_pend_reg  <= head_job.left_chg;
            right_pend_reg <= head_job.right_chg;
        end
        else if (done)
            job_valid_reg <= 1'b0;
        else if (emit)
        begin
            if (move_pend_reg)
                move_pend_reg <= 1'b0;
            else
                left_pend_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= sel_kind;
            btn_reg   <= sel_btn;
            pos_x_reg <= job_reg.pos_x;
            pos_y_reg <= job_reg.pos_y;
            rel_x_reg <= sel_move ? job_reg.rel_x : 8'sd0;
            rel_y_reg <= sel_move ? job_reg.rel_y : 9'sd0;
            last_reg  <= sel_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, rel_y_reg, rel_x_reg, pos_y_reg, pos_x_reg};
    assign m_tuser  = {btn_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### rtl/core/mouse_packet_cursor_tracker_unit.sv
// top level of the mouse packet cursor tracker
//
//  channel   | dir | beat contents
//  ----------+-----+-----------------------------------------------------
//  s_t*      | in  | one packet: buttons_byte, delta_x, delta_y
//  m_t*      | out | one result: position, motion, kind, button, last
//  apb       | in  | screen_width at 0x0, screen_height at 0x4
//
//  a packet is taken while the queue has room; the back part sends one
//  result per cycle unless stalled; a packet uses 1 to 3 beats of the single
//  result port; its first result passes the queue entry, job and output
//  registers. reset sets the screen to 640 x 480; the cursor centers on the
//  first packet. either side may stall; the four-entry queue decouples them.
`default_nettype none

module mouse_packet_cursor_tracker_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mpct_pkg::IN_DATA_W-1:0] s_tdata,   // buttons_byte, delta_x, delta_y
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [mpct_pkg::OUT_DATA_W-1:0]     m_tdata,   // pos_x, pos_y, rel_x, rel_y, pad
    output logic [mpct_pkg::OUT_USER_W-1:0]     m_tuser,   // event_kind, button_id
    output logic                                m_tlast,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mpct_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import mpct_pkg::*;

    logic [15:0]   screen_width_reg, screen_height_reg;
    logic          cfg_write;
    logic          accept;
    job_t          push_job, head_job;
    queue_status_t q_status;
    logic          pop;
    logic          prev_last_reg;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[15:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = {16'd0, screen_width_reg};
            REG_SCREEN_HEIGHT: prdata = {16'd0, screen_height_reg};
            default:           prdata = '0;
        endcase
    end

    // input beat handshake
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    mpct_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .buttons_byte  (s_tdata[7:0]),
        .delta_x       ($signed(s_tdata[15:8])),
        .delta_y       ($signed(s_tdata[23:16])),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .job           (push_job)
    );

    mpct_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    mpct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .queue_empty (q_status.empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // remembers whether the previous result closed its packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_last_reg <= 1'b1;
        else if (m_tvalid && m_tready)
            prev_last_reg <= m_tlast;
    end

    // a packet's results open with a move result and only there
    a_move_opens_packet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser[1:0] == KIND_MOVE) == prev_last_reg))
        else $error("move result out of place");

    // button results carry no motion, move results carry no button
    a_button_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != KIND_MOVE) |-> (m_tdata[48:32] == '0))
        else $error("button result with motion");

    a_move_no_button: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == KIND_MOVE) |-> (m_tuser[3:2] == BTN_NONE))
        else $error("move result with button id");

    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue overflow");

endmodule

`default_nettype wire
